@@ hw/rtl/rrd_pkg.sv @@
package rrd_pkg;

  localparam logic [7:0] StartByte   = 8'haa;
  localparam logic [7:0] EndByte     = 8'h55;
  localparam logic [7:0] CodeRead    = 8'h7f;
  localparam logic [7:0] CodeWrite   = 8'h7e;
  localparam logic [7:0] CodeReset   = 8'h7d;
  localparam logic [7:0] CodeUnknown = 8'hfe;
  localparam logic [7:0] CodeError   = 8'hfd;

  localparam logic [3:0] LenRead     = 4'd9;
  localparam logic [3:0] LenWrite    = 4'd5;
  localparam logic [3:0] LenReset    = 4'd3;
  localparam logic [3:0] LenError    = 4'd4;

  localparam logic [3:0] PosHunt     = 4'd0;
  localparam logic [3:0] PosCode     = 4'd1;
  localparam logic [3:0] PosAddrHi   = 4'd2;
  localparam logic [3:0] PosAddrLo   = 4'd3;
  localparam logic [3:0] PosDataLo   = 4'd4;
  localparam logic [3:0] PosDataHi   = 4'd7;

endpackage

@@ hw/rtl/register_response_deframer_top.sv @@
// Bytes pass the input register, then the result register (status, read_data).
// Throughput: one byte per cycle. While a finished result waits to be taken, one
// more byte can enter the input register, then the input stalls until the result goes.
// A byte that does not end a frame or break framing gives no result.
// Reset (rst_ni low, asynchronous) clears the frame state to hunting for a start
// byte and empties both the input register and the result register.
module register_response_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        mode_i,
  input  logic [15:0] expected_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [31:0] read_data_o
);

  import rrd_pkg::*;

  logic        stage_valid_q, stage_valid_d;
  logic [7:0]  byte_q;
  logic        mode_q;
  logic [15:0] addr_q;

  logic [3:0]  pos_q, pos_d;
  logic [3:0]  len_q, len_d;
  logic        mis_q, mis_d;
  logic [31:0] data_q, data_d;
  logic        lmode_q, lmode_d;
  logic [15:0] laddr_q, laddr_d;

  logic        out_valid_q, out_valid_d;
  logic        status_q;
  logic [31:0] rdata_q;

  logic        out_free;
  logic        fire;
  logic        in_accept;
  logic        emit;
  logic        emit_status;
  logic [31:0] emit_data;
  logic        bad_code;
  logic [7:0]  want_code;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = stage_valid_q && out_free;
  assign in_stall_o = stage_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign want_code  = lmode_q ? CodeRead : CodeWrite;

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    mis_d       = mis_q;
    data_d      = data_q;
    lmode_d     = lmode_q;
    laddr_d     = laddr_q;
    emit        = 1'b0;
    emit_status = 1'b1;
    emit_data   = '0;
    bad_code    = 1'b0;
    if (pos_q == PosHunt) begin
      lmode_d = mode_q;
      laddr_d = addr_q;
      mis_d   = 1'b0;
      data_d  = '0;
      len_d   = '0;
      if (byte_q != StartByte) begin
        emit = 1'b1;
      end else begin
        pos_d = PosCode;
      end
    end else begin
      if (pos_q == PosCode) begin
        unique case (byte_q) inside
          CodeRead:  len_d = LenRead;
          CodeWrite: len_d = LenWrite;
          CodeReset: len_d = LenReset;
          CodeError, CodeUnknown: len_d = LenError;
          default:   bad_code = 1'b1;
        endcase
        if (bad_code) begin
          pos_d = PosHunt;
          len_d = '0;
          emit  = 1'b1;
        end else if (byte_q != want_code) begin
          mis_d = 1'b1;
        end
      end else if (!mis_q) begin
        if (pos_q == PosAddrHi) begin
          if (byte_q != laddr_q[15:8]) mis_d = 1'b1;
        end else if (pos_q == PosAddrLo) begin
          if (byte_q != laddr_q[7:0]) mis_d = 1'b1;
        end else if (pos_q == len_q - 4'd1) begin
          if (byte_q != EndByte) mis_d = 1'b1;
        end else if (lmode_q && pos_q >= PosDataLo && pos_q <= PosDataHi) begin
          data_d = {data_q[23:0], byte_q};
        end
      end
      if (!bad_code) begin
        if ({1'b0, pos_q} + 5'd1 >= {1'b0, len_d}) begin
          emit        = 1'b1;
          emit_status = mis_d;
          emit_data   = (!mis_d && lmode_q) ? data_d : '0;
          pos_d       = PosHunt;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
    end
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_accept) begin
      stage_valid_d = 1'b1;
    end else if (fire) begin
      stage_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = fire && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      pos_q         <= PosHunt;
      len_q         <= '0;
      mis_q         <= 1'b0;
      data_q        <= '0;
      lmode_q       <= 1'b0;
      laddr_q       <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
      if (fire) begin
        pos_q   <= pos_d;
        len_q   <= len_d;
        mis_q   <= mis_d;
        data_q  <= data_d;
        lmode_q <= lmode_d;
        laddr_q <= laddr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= rx_byte_i;
      mode_q <= mode_i;
      addr_q <= expected_address_i;
    end
    if (fire && emit && out_free) begin
      status_q <= emit_status;
      rdata_q  <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < LenRead)
    else $error("frame position beyond longest frame");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q >= PosAddrHi |-> pos_q < len_q)
    else $error("frame position past frame length");

  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_data_o != '0 |-> !status_o)
    else $error("read data on failed reply");

  a_emit_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit |=> pos_q == PosHunt)
    else $error("result without return to hunting");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rrd_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 4;

  typedef struct {
    logic        status;
    logic [31:0] read_data;
  } reply_t;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i          = 8'h00;
  logic        mode_i             = 1'b0;
  logic [15:0] expected_address_i = 16'h0000;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic        status_o;
  logic [31:0] read_data_o;

  reply_t pending_replies[$];
  reply_t head_reply;

  logic [3:0]  frm_pos  = PosHunt;
  logic [3:0]  frm_len  = 4'd0;
  logic        frm_bad  = 1'b0;
  logic [31:0] frm_data = 32'd0;
  logic        frm_mode = 1'b0;
  logic [15:0] frm_addr = 16'd0;

  int idle_pct         = 0;
  int stall_pct        = 0;
  int holdoff_requests = 0;
  int holdoff_served   = 0;
  int holdoff_left     = 0;
  int bytes_sent       = 0;
  int replies_checked  = 0;
  int failures         = 0;

  register_response_deframer_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .mode_i             (mode_i),
    .expected_address_i (expected_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .read_data_o        (read_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int frame_bytes(logic [7:0] code);
    case (code) inside
      CodeRead:               return int'(LenRead);
      CodeWrite:              return int'(LenWrite);
      CodeReset:              return int'(LenReset);
      CodeError, CodeUnknown: return int'(LenError);
      default:                return 2;
    endcase
  endfunction

  function automatic void predict_reply(logic [7:0] b, logic m, logic [15:0] a);
    logic [7:0] want;
    reply_t     r;
    r.status    = 1'b1;
    r.read_data = 32'd0;
    if (frm_pos == PosHunt) begin
      frm_mode = m;
      frm_addr = a;
      frm_bad  = 1'b0;
      frm_data = 32'd0;
      frm_len  = 4'd0;
      if (b != StartByte) begin
        pending_replies.push_back(r);
      end else begin
        frm_pos = PosCode;
      end
      return;
    end
    if (frm_pos == PosCode) begin
      want = frm_mode ? CodeRead : CodeWrite;
      case (b) inside
        CodeRead:               frm_len = LenRead;
        CodeWrite:              frm_len = LenWrite;
        CodeReset:              frm_len = LenReset;
        CodeError, CodeUnknown: frm_len = LenError;
        default: begin
          frm_pos = PosHunt;
          frm_len = 4'd0;
          pending_replies.push_back(r);
          return;
        end
      endcase
      if (b != want) frm_bad = 1'b1;
    end else if (!frm_bad) begin
      if (frm_pos == PosAddrHi) begin
        if (b != frm_addr[15:8]) frm_bad = 1'b1;
      end else if (frm_pos == PosAddrLo) begin
        if (b != frm_addr[7:0]) frm_bad = 1'b1;
      end else if (frm_pos == frm_len - 4'd1) begin
        if (b != EndByte) frm_bad = 1'b1;
      end else if (frm_mode && frm_pos >= PosDataLo && frm_pos <= PosDataHi) begin
        frm_data = {frm_data[23:0], b};
      end
    end
    if (int'(frm_pos) + 1 >= int'(frm_len)) begin
      r.status    = frm_bad;
      r.read_data = (!frm_bad && frm_mode) ? frm_data : 32'd0;
      pending_replies.push_back(r);
      frm_pos = PosHunt;
    end else begin
      frm_pos = frm_pos + 4'd1;
    end
  endfunction

  always @(posedge clk_i) begin
    if (holdoff_requests != holdoff_served) begin
      holdoff_served <= holdoff_served + 1;
      holdoff_left   <= HoldOffCycles;
      out_stall_i    <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request pending: status %0d, read_data %h",
               status_o, read_data_o);
        failures++;
      end else begin
        head_reply = pending_replies.pop_front();
        replies_checked++;
        if (status_o !== head_reply.status) begin
          $error("status: expected %0d, actual %0d", head_reply.status, status_o);
          failures++;
        end
        if (read_data_o !== head_reply.read_data) begin
          $error("read_data: expected %h, actual %h", head_reply.read_data, read_data_o);
          failures++;
        end
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic m, input logic [15:0] a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    rx_byte_i          <= b;
    mode_i             <= m;
    expected_address_i <= a;
    do @(posedge clk_i); while (in_stall_o);
    predict_reply(b, m, a);
    bytes_sent++;
  endtask

  // corrupt_at < 0 leaves the frame intact
  task automatic send_frame(input logic m, input logic [15:0] a, input logic [7:0] code,
                            input int corrupt_at, input logic [31:0] payload);
    int         len;
    logic [7:0] b;
    len = frame_bytes(code);
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = StartByte;
      else if (i == 1) b = code;
      else if (i == len - 1) b = EndByte;
      else if (i == 2) b = a[15:8];
      else if (i == 3) b = a[7:0];
      else b = payload[31 - 8 * (i - 4) -: 8];
      if (i == corrupt_at) b = b ^ 8'($urandom_range(1, 255));
      if (i == 0) send_request(b, m, a);
      else send_request(b, 1'($urandom_range(1)), 16'($urandom_range(65535)));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_directed_frames();
    idle_pct  = 0;
    stall_pct = 0;
    send_frame(1'b1, 16'hffff, CodeRead, -1, 32'hffffffff);
    send_frame(1'b0, 16'h0000, CodeWrite, -1, 32'h0);
    // read reply while a write acknowledge is expected
    send_frame(1'b0, 16'h1234, CodeRead, -1, 32'hdeadbeef);
    send_request(8'h00, 1'b1, 16'hffff);
    send_frame(1'b1, 16'h00ff, 8'h00, -1, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_frames(input int n, input int idle, input int stall);
    int          target;
    int          pick;
    logic        m;
    logic [15:0] a;
    logic [7:0]  code;
    idle_pct  = idle;
    stall_pct = stall;
    target    = bytes_sent + n;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      m    = 1'($urandom_range(1));
      a    = 16'($urandom_range(65535));
      code = m ? CodeRead : CodeWrite;
      if (pick < 55) begin
        send_frame(m, a, code, -1, $urandom);
      end else if (pick < 70) begin
        send_frame(m, a, code, $urandom_range(frame_bytes(code) - 1), $urandom);
      end else if (pick < 85) begin
        case ($urandom_range(4))
          0:       code = CodeRead;
          1:       code = CodeWrite;
          2:       code = CodeReset;
          3:       code = CodeError;
          default: code = CodeUnknown;
        endcase
        send_frame(m, a, code, -1, $urandom);
      end else if (pick < 93) begin
        send_frame(m, a, 8'($urandom_range(255)), -1, $urandom);
      end else begin
        repeat ($urandom_range(1, 3))
          send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                       16'($urandom_range(65535)));
      end
    end
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    int   target;
    logic m;
    idle_pct  = 0;
    stall_pct = 0;
    holdoff_requests <= holdoff_requests + 1;
    target = bytes_sent + 60;
    while (bytes_sent < target) begin
      m = 1'($urandom_range(1));
      send_frame(m, 16'($urandom_range(65535)), m ? CodeRead : CodeWrite, -1, $urandom);
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_random_frames(190, 0, 0);
    test_random_frames(190, 47, 0);
    test_random_frames(190, 0, 47);
    test_random_frames(190, 33, 33);
    test_output_holdoff();
    $display("Fed %0d reply bytes (good, corrupted, mismatched and noise frames)", bytes_sent);
    $display("and checked %0d reports under idle, stall and long output hold-off.",
             replies_checked);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rrd_pkg.sv
hw/rtl/register_response_deframer_top.sv
tb/sv/testbench.sv
